@@ rtl/lwh_pkg.sv @@
// Shared types and constants for the literal weight heuristic table.
// Used by lwh_alu, lwh_score_mem and literal_weight_heuristic_table; no dependencies.
package lwh_pkg;

    localparam int MAX_VARS  = 1024;
    localparam int FRAC_BITS = 49;
    localparam int SKIP_LEN  = 50;

    localparam int SCORE_W  = 64;
    localparam int ALU_W    = SCORE_W + 1;
    localparam int ADDR_W   = $clog2(MAX_VARS);
    localparam int SHAMT_W  = $clog2(SCORE_W);
    localparam int CLAUSE_W = 20;
    localparam int REM_W    = CLAUSE_W;
    localparam int DIV_STEPS = ALU_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  var_index;
        logic        negated;
        logic [15:0] clause_len;
    } cmd_t;

    typedef struct packed {
        logic               prefer_negative;
        logic [SCORE_W-1:0] activity;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  rd_addr;
        logic               we_pos;
        logic               we_neg;
        logic [ADDR_W-1:0]  wr_addr;
        logic [SCORE_W-1:0] wr_data;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_RD_SUM,
        ST_RD_CMP,
        ST_DIV,
        ST_CLEAR
    } state_t;

endpackage

@@ rtl/literal_weight_heuristic_table.sv @@
// Literal weight heuristic table: per-literal score store and activity divider.
// Depends on lwh_pkg, lwh_alu and lwh_score_mem.
//
// A transaction is taken when start is high and busy is low. An add is a memory read,
// then a saturating add and write back through the shared adder. A read is busy
// through a score sum, a phase compare and then 65 restoring divide steps through the
// same adder; its result appears on result, with done high for a single cycle, in the
// cycle in which busy drops; the receiver cannot stall it. A clear, and the pass after
// reset, sweeps both score memories one address per cycle. Adds that fall outside the
// scored range and unused ops are dropped without raising busy.
module literal_weight_heuristic_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  lwh_pkg::cmd_t                cmd,
    output logic                         busy,
    output logic                         done,
    output lwh_pkg::result_t             result,
    input  logic                         cfg_we,
    input  logic [lwh_pkg::CLAUSE_W-1:0] cfg_wdata
);
    import lwh_pkg::*;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [ALU_W-1:0]    div_reg;
    logic [REM_W-1:0]    rem_reg;
    logic                pref_reg;
    logic                done_reg;
    result_t             result_reg;
    logic [CLAUSE_W-1:0] clause_count_reg;

    mem_req_t            mem_req;
    logic [SCORE_W-1:0]  pos_rd, neg_rd;
    logic [ALU_W-1:0]    alu_a, alu_b;
    logic                alu_sub;
    logic [ALU_W:0]      alu_res;

    logic                accept;
    logic                var_ok, add_ok;
    logic [SHAMT_W-1:0]  shamt;
    logic [SCORE_W-1:0]  inc;
    logic [CLAUSE_W-1:0] divisor;
    logic [REM_W:0]      rem_shift;
    logic                no_borrow;
    logic                clr_last, div_last;
    logic [ALU_W-1:0]    quot_next;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign var_ok = (32'(cmd.var_index) < MAX_VARS);
    assign add_ok = var_ok && (cmd.clause_len < 16'(SKIP_LEN))
                    && (cmd.clause_len <= 16'(FRAC_BITS));

    // weight 2^-len in fixed point; len was checked at accept
    assign shamt = SHAMT_W'(16'(FRAC_BITS) - cmd_reg.clause_len);
    assign inc   = SCORE_W'(1) << shamt;

    assign divisor   = (clause_count_reg == '0) ? CLAUSE_W'(1) : clause_count_reg;
    assign rem_shift = {rem_reg, div_reg[ALU_W-1]};
    assign no_borrow = alu_res[ALU_W];
    assign quot_next = {div_reg[ALU_W-2:0], no_borrow};
    assign clr_last  = (clr_cnt_reg == ADDR_W'(MAX_VARS - 1));
    assign div_last  = (step_reg == STEP_W'(DIV_STEPS - 1));

    lwh_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res)
    );

    lwh_score_mem u_mem (
        .clk    (clk),
        .req    (mem_req),
        .pos_rd (pos_rd),
        .neg_rd (neg_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        OP_ADD:   state_next = add_ok ? ST_ADD_WR : ST_IDLE;
                        OP_READ:  state_next = var_ok ? ST_RD_SUM : ST_IDLE;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_WR: state_next = ST_IDLE;
            ST_RD_SUM: state_next = ST_RD_CMP;
            ST_RD_CMP: state_next = ST_DIV;
            ST_DIV:    state_next = div_last ? ST_IDLE : ST_DIV;
            ST_CLEAR:  state_next = clr_last ? ST_IDLE : ST_CLEAR;
            default:   state_next = ST_IDLE;
        endcase
    end

    // memory and adder control
    always_comb
    begin
        mem_req.rd_addr = ADDR_W'(cmd_reg.var_index);
        mem_req.we_pos  = 1'b0;
        mem_req.we_neg  = 1'b0;
        mem_req.wr_addr = ADDR_W'(cmd_reg.var_index);
        mem_req.wr_data = alu_res[SCORE_W] ? '1 : alu_res[SCORE_W-1:0];
        alu_a           = {1'b0, pos_rd};
        alu_b           = {1'b0, neg_rd};
        alu_sub         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.rd_addr = ADDR_W'(cmd.var_index);
            end
            ST_ADD_WR:
            begin
                alu_a          = {1'b0, cmd_reg.negated ? neg_rd : pos_rd};
                alu_b          = {1'b0, inc};
                mem_req.we_pos = !cmd_reg.negated;
                mem_req.we_neg = cmd_reg.negated;
            end
            ST_RD_SUM:
            begin
                alu_a = {1'b0, pos_rd};
                alu_b = {1'b0, neg_rd};
            end
            ST_RD_CMP:
            begin
                // carry set when neg >= pos
                alu_a   = {1'b0, neg_rd};
                alu_b   = {1'b0, pos_rd};
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_a   = ALU_W'(rem_shift);
                alu_b   = ALU_W'(divisor);
                alu_sub = 1'b1;
            end
            ST_CLEAR:
            begin
                mem_req.we_pos  = 1'b1;
                mem_req.we_neg  = 1'b1;
                mem_req.wr_addr = clr_cnt_reg;
                mem_req.wr_data = '0;
            end
            default:
            begin
                mem_req.rd_addr = ADDR_W'(cmd_reg.var_index);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            step_reg         <= '0;
            done_reg         <= 1'b0;
            clause_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DIV && div_last)
                         || (accept && cmd.op == OP_READ && !var_ok);
            if (cfg_we)
            begin
                clause_count_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_DIV)
            begin
                step_reg <= div_last ? '0 : step_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            if (cmd.op == OP_READ && !var_ok)
            begin
                result_reg.prefer_negative <= 1'b1;
                result_reg.activity        <= '0;
            end
        end
        if (state_reg == ST_RD_SUM)
        begin
            div_reg <= alu_res[ALU_W-1:0];
            rem_reg <= '0;
        end
        if (state_reg == ST_RD_CMP)
        begin
            pref_reg <= alu_res[ALU_W];
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= no_borrow ? alu_res[REM_W-1:0] : rem_shift[REM_W-1:0];
            div_reg <= quot_next;
            if (div_last)
            begin
                result_reg.prefer_negative <= pref_reg;
                result_reg.activity <= quot_next[ALU_W-1] ? '1 : quot_next[SCORE_W-1:0];
            end
        end
    end

    a_div_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_last) |=> (done && state_reg == ST_IDLE))
        else $error("divider finished without a result strobe");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE || state_reg == ST_ADD_WR
                  || state_reg == ST_RD_SUM || state_reg == ST_CLEAR))
        else $error("result strobe while a read is still in the divider");

    a_add_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD_WR) |=> (state_reg == ST_IDLE))
        else $error("add did not return to idle after write back");

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && !clr_last) |=>
        (state_reg == ST_CLEAR && clr_cnt_reg == $past(clr_cnt_reg) + 1'b1))
        else $error("clear sweep skipped or left early");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < divisor))
        else $error("divider remainder out of range");

endmodule

@@ rtl/lwh_alu.sv @@
// Shared add/subtract unit: score update, score sum, phase compare, divider step.
// Depends on lwh_pkg.
module lwh_alu (
    input  logic [lwh_pkg::ALU_W-1:0] a,
    input  logic [lwh_pkg::ALU_W-1:0] b,
    input  logic                      sub,
    output logic [lwh_pkg::ALU_W:0]   res
);
    import lwh_pkg::*;

    // res[ALU_W] is carry out; on subtract it is set when a >= b
    assign res = {1'b0, a} + {1'b0, b ^ {ALU_W{sub}}} + (ALU_W+1)'(sub);

endmodule

@@ rtl/lwh_score_mem.sv @@
// Positive and negative literal score memories, one write and one registered read each.
// Depends on lwh_pkg.
module lwh_score_mem (
    input  logic                        clk,
    input  lwh_pkg::mem_req_t           req,
    output logic [lwh_pkg::SCORE_W-1:0] pos_rd,
    output logic [lwh_pkg::SCORE_W-1:0] neg_rd
);
    import lwh_pkg::*;

    logic [SCORE_W-1:0] pos_mem [MAX_VARS];
    logic [SCORE_W-1:0] neg_mem [MAX_VARS];

    always_ff @(posedge clk)
    begin
        if (req.we_pos)
        begin
            pos_mem[req.wr_addr] <= req.wr_data;
        end
        pos_rd <= pos_mem[req.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.we_neg)
        begin
            neg_mem[req.wr_addr] <= req.wr_data;
        end
        neg_rd <= neg_mem[req.rd_addr];
    end

endmodule
